// File: design/windowed_substring_search_macros.svh
// Assertion helpers, included by wss_match_core.sv.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef WINDOWED_SUBSTRING_SEARCH_MACROS_SVH
`define WINDOWED_SUBSTRING_SEARCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WSS_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: design/wss_pkg.sv
package wss_pkg;

  // Item field widths
  localparam int TEXT_BYTE_W = 8;
  localparam int POS_W       = 16;

  // Configuration field widths
  localparam int PLEN_W    = 5;
  localparam int WSTART_W  = 16;
  localparam int WLEN_W    = 17;
  localparam int PAT_BYTES = 16;
  localparam int PAT_IDX_W = 4;

  // APB port geometry: 64-bit registers at 8-byte stride
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 6;
  localparam int REG_IDX_W = 3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_MODE    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_START   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH  = 3'd5;

  typedef struct packed {
    logic [PAT_BYTES-1:0][TEXT_BYTE_W-1:0] pattern;
    logic [PLEN_W-1:0]                     pattern_length;
    logic                                  window_mode;
    logic [WSTART_W-1:0]                   window_start;
    logic [WLEN_W-1:0]                     window_length;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
  } result_t;

endpackage

// File: design/wss_ifs.sv
interface wss_text_if;
  logic                           valid;
  logic                           ready;
  logic [wss_pkg::TEXT_BYTE_W-1:0] text_byte;
  logic                           last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface wss_result_if;
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [wss_pkg::POS_W-1:0] match_position;

  modport source (output valid, output found, output match_position, input ready);
  modport sink (input valid, input found, input match_position, output ready);
endinterface

// File: design/windowed_substring_search.sv
// Streaming substring search over a byte text with an optional window.
// Channel text (sink): one text byte per item, last_byte marks the end of a text.
// Channel result (source): one item per text, given for its last byte:
//   found, and match_position (first allowed match start, 0 when not found).
// APB port: pattern bytes, pattern length, window mode, start and length, written
//   while no text is in flight; registers sit at an 8-byte stride.
// Throughput: one text byte per cycle unless a last byte waits on a full result
//   register; the history shift, the 16-byte parallel compare and the window check
//   fit between the input register and the state/result registers.
// A result is computed from the input register and held in the result register.
// The text and result channels are parted by the input register and the result
//   register: with a result waiting, the block still takes bytes until the next
//   last byte, which holds in the input register until the result is taken.
// Reset (rst, synchronous) clears the config registers, byte count, recorded match
//   and both channel valids; the block accepts items in the cycle after.
module windowed_substring_search #(
  parameter int              PATTERN_MAX = 16,
  parameter longint unsigned TEXT_MAX    = 65536
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wss_pkg::ADDR_W-1:0] paddr,
  input  logic [wss_pkg::DATA_W-1:0] pwdata,
  output logic [wss_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  wss_text_if.sink                   text,
  wss_result_if.source               result
);

  wss_pkg::cfg_t    cfg;
  wss_pkg::result_t res;
  logic             res_load;
  logic             out_free;

  wss_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wss_match_core #(
    .PATTERN_MAX (PATTERN_MAX),
    .TEXT_MAX    (TEXT_MAX)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .text     (text),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  wss_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (res_load),
    .res    (res),
    .free   (out_free),
    .result (result)
  );

endmodule

// File: design/wss_cfg_regs.sv
module wss_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wss_pkg::ADDR_W-1:0] paddr,
  input  logic [wss_pkg::DATA_W-1:0] pwdata,
  output logic [wss_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output wss_pkg::cfg_t              cfg
);

  logic [wss_pkg::DATA_W-1:0]    pattern_low;
  logic [wss_pkg::DATA_W-1:0]    pattern_high;
  logic [wss_pkg::PLEN_W-1:0]    pattern_length;
  logic                          window_mode;
  logic [wss_pkg::WSTART_W-1:0]  window_start;
  logic [wss_pkg::WLEN_W-1:0]    window_length;
  logic [wss_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[wss_pkg::ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      window_mode    <= 1'b0;
      window_start   <= '0;
      window_length  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        wss_pkg::REG_PATTERN_LOW:    pattern_low    <= pwdata;
        wss_pkg::REG_PATTERN_HIGH:   pattern_high   <= pwdata;
        wss_pkg::REG_PATTERN_LENGTH: pattern_length <= pwdata[wss_pkg::PLEN_W-1:0];
        wss_pkg::REG_WINDOW_MODE:    window_mode    <= pwdata[0];
        wss_pkg::REG_WINDOW_START:   window_start   <= pwdata[wss_pkg::WSTART_W-1:0];
        wss_pkg::REG_WINDOW_LENGTH:  window_length  <= pwdata[wss_pkg::WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      wss_pkg::REG_PATTERN_LOW:    prdata = pattern_low;
      wss_pkg::REG_PATTERN_HIGH:   prdata = pattern_high;
      wss_pkg::REG_PATTERN_LENGTH: prdata = wss_pkg::DATA_W'(pattern_length);
      wss_pkg::REG_WINDOW_MODE:    prdata = wss_pkg::DATA_W'(window_mode);
      wss_pkg::REG_WINDOW_START:   prdata = wss_pkg::DATA_W'(window_start);
      wss_pkg::REG_WINDOW_LENGTH:  prdata = wss_pkg::DATA_W'(window_length);
      default:                     prdata = '0;
    endcase
  end

  // Byte 0 of the pattern sits in the low bits of pattern_low
  assign cfg.pattern        = {pattern_high, pattern_low};
  assign cfg.pattern_length = pattern_length;
  assign cfg.window_mode    = window_mode;
  assign cfg.window_start   = window_start;
  assign cfg.window_length  = window_length;

endmodule

// File: design/wss_match_core.sv
`include "windowed_substring_search_macros.svh"

module wss_match_core #(
  parameter int              PATTERN_MAX = 16,
  parameter longint unsigned TEXT_MAX    = 65536
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wss_pkg::cfg_t          cfg,
  wss_text_if.sink               text,
  input  logic                   out_free,
  output logic                   res_load,
  output wss_pkg::result_t       res
);

  localparam int CW     = $clog2(TEXT_MAX + 1);
  localparam int CMP_N  = (PATTERN_MAX < wss_pkg::PAT_BYTES) ? PATTERN_MAX
                                                             : wss_pkg::PAT_BYTES;
  localparam int WW     = ((CW > wss_pkg::WLEN_W) ? CW : wss_pkg::WLEN_W) + 2;
  localparam int BW     = wss_pkg::TEXT_BYTE_W;
  localparam int LW     = wss_pkg::PLEN_W;

  // Input register
  logic          stage_valid;
  logic [BW-1:0] byte_q;
  logic          last_q;
  logic          go;

  // Per-text state
  logic [BW-1:0]            hist [PATTERN_MAX];
  logic [BW-1:0]            hist_new [PATTERN_MAX];
  logic [CW-1:0]            bytes_seen;
  logic                     match_recorded;
  logic [wss_pkg::POS_W-1:0] first_pos;

  logic [CW-1:0]            bytes_seen_next;
  logic [CW-1:0]            seen_inc;
  logic [CW-1:0]            s;
  logic [LW-1:0]            len;
  logic                     usable;
  logic                     counting;
  logic                     check;
  logic [CMP_N-1:0]         byte_ok;
  logic                     win_fail;
  logic                     hit;
  logic                     rec_now;
  logic [wss_pkg::POS_W-1:0] pos_now;
  logic [WW-1:0]            win_end;
  logic                     win_ok;
  logic                     fin_found;

  assign go         = stage_valid && (!last_q || out_free);
  assign text.ready = !stage_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      stage_valid <= 1'b1;
    end else if (go) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      byte_q <= text.text_byte;
      last_q <= text.last_byte;
    end
  end

  // History after this byte, newest at index 0
  always_comb begin
    hist_new[0] = byte_q;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      hist_new[i] = hist[i-1];
    end
  end

  assign len      = cfg.pattern_length;
  assign usable   = (int'(len) <= PATTERN_MAX) && (int'(len) <= wss_pkg::PAT_BYTES);
  assign counting = 64'(bytes_seen) < TEXT_MAX;
  assign seen_inc = bytes_seen + CW'(1);
  assign bytes_seen_next = counting ? seen_inc : bytes_seen;
  assign check    = counting && usable && (len != '0) && (seen_inc >= CW'(len))
                    && !match_recorded;
  assign s        = seen_inc - CW'(len);

  // Parallel byte compare: history slot k holds pattern byte len-1-k
  always_comb begin
    logic [LW-1:0] idx;
    for (int k = 0; k < CMP_N; k++) begin
      idx        = len - LW'(1) - LW'(k);
      byte_ok[k] = (LW'(k) >= len) ||
                   (hist_new[k] == cfg.pattern[idx[wss_pkg::PAT_IDX_W-1:0]]);
    end
  end

  // Window containment for a candidate match
  assign win_end  = WW'(cfg.window_start) + WW'(cfg.window_length);
  assign win_fail = (WW'(s) < WW'(cfg.window_start)) || (WW'(s) + WW'(len) > win_end);
  assign hit      = check && (&byte_ok) && (!cfg.window_mode || !win_fail);
  assign rec_now  = match_recorded || hit;
  assign pos_now  = hit ? wss_pkg::POS_W'(s) : first_pos;

  // End-of-text verdict
  assign win_ok    = (WW'(bytes_seen_next) >= win_end) &&
                     (wss_pkg::WLEN_W'(len) <= cfg.window_length);
  assign fin_found = usable && (!cfg.window_mode || win_ok) && ((len == '0) || rec_now);

  always_comb begin
    res.found = fin_found;
    if (!fin_found) begin
      res.match_position = '0;
    end else if (len == '0) begin
      res.match_position = cfg.window_mode ? cfg.window_start : '0;
    end else begin
      res.match_position = pos_now;
    end
  end

  assign res_load = go && last_q;

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      match_recorded <= 1'b0;
    end else if (go) begin
      if (last_q) begin
        bytes_seen     <= '0;
        match_recorded <= 1'b0;
      end else begin
        bytes_seen     <= bytes_seen_next;
        match_recorded <= rec_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      first_pos <= pos_now;
      for (int i = 0; i < PATTERN_MAX; i++) begin
        hist[i] <= hist_new[i];
      end
    end
  end

  `WSS_ASSERT_IMP(a_seen_bounded, 1'b1, 64'(bytes_seen) <= TEXT_MAX, "byte count over limit")
  `WSS_ASSERT_IMP(a_result_on_last, res_load, stage_valid && last_q && out_free,
                  "result without a last byte")
  `WSS_ASSERT_NEXT(a_clear_after_last, go && last_q,
                   bytes_seen == '0 && !match_recorded, "text state not cleared")
  `WSS_ASSERT_NEXT(a_match_sticky, match_recorded && !(go && last_q), match_recorded,
                   "recorded match lost mid-text")

endmodule

// File: design/wss_out_reg.sv
module wss_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  wss_pkg::result_t res,
  output logic             free,
  wss_result_if.source     result
);

  logic             out_valid;
  wss_pkg::result_t out_data;

  assign free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.found          = out_data.found;
  assign result.match_position = out_data.match_position;

endmodule
